[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the drive unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define FPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpd assertion failed");

// Next-cycle implication, masked while reset is low.
`define FPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpd assertion failed");

// Next-cycle implication that also holds across reset.
`define FPD_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fpd assertion failed");

`endif

[hw/rtl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Widths, register indexes, reset values and shared types of the filtered
// PID drive unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

    // Field widths
    localparam int FRAC_W     = 16;
    localparam int ERR_W      = 32;
    localparam int COEF_W     = 32;
    localparam int LIM_W      = 8;
    localparam int DRV_W      = 25;                 // clamped drive, Q8.16
    localparam int OUT_W      = 26;                 // drive plus offset, Q9.16
    localparam int EPROD_W    = COEF_W + ERR_W;     // error term, Q.16
    localparam int DPROD_W    = COEF_W + DRV_W;     // drive term, Q.32
    localparam int DTERM_W    = DPROD_W - FRAC_W;   // drive term, Q.16
    localparam int ACC_W      = EPROD_W + 3;        // five-term sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ERR0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ERR1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ERR2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd7;

    // Reset values
    localparam logic [LIM_W-1:0] FRICTION_RST = 8'd32;
    localparam logic [LIM_W-1:0] LIMIT_RST    = 8'd255;

    // Error saturation bounds
    localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

    // Largest drive magnitude: two full 8-bit units in Q.16
    localparam logic signed [OUT_W-1:0] DRIVE_MAX = 26'sd33423360;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_err0;
        logic signed [COEF_W-1:0] coef_err1;
        logic signed [COEF_W-1:0] coef_err2;
        logic signed [COEF_W-1:0] coef_out1;
        logic signed [COEF_W-1:0] coef_out2;
        logic signed [ERR_W-1:0]  setpoint;
        logic [LIM_W-1:0]         friction_offset;
        logic [LIM_W-1:0]         drive_limit;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/fpd_ifs.sv]
// ----------------------------------------------------------------------------
// fpd_ifs
// Valid/ready channel interfaces: measurement in, drive out, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpd_in_if import fpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] measured;

    modport source (output valid, output measured, input ready);
    modport sink   (input valid, input measured, output ready);
endinterface

interface fpd_out_if import fpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] drive;
    logic                    clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface fpd_cfg_if import fpd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fpd_cfg.sv]
// ----------------------------------------------------------------------------
// fpd_cfg
// Register file for coefficients, setpoint, friction offset and drive limit.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_cfg import fpd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpd_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always take a write beat
    assign i_cfg.ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COEF_ERR0: n_cfg.coef_err0       = i_cfg.data;
                REG_COEF_ERR1: n_cfg.coef_err1       = i_cfg.data;
                REG_COEF_ERR2: n_cfg.coef_err2       = i_cfg.data;
                REG_COEF_OUT1: n_cfg.coef_out1       = i_cfg.data;
                REG_COEF_OUT2: n_cfg.coef_out2       = i_cfg.data;
                REG_SETPOINT:  n_cfg.setpoint        = i_cfg.data;
                REG_FRICTION:  n_cfg.friction_offset = i_cfg.data[LIM_W-1:0];
                REG_LIMIT:     n_cfg.drive_limit     = i_cfg.data[LIM_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_err0       <= '0;
            r_cfg.coef_err1       <= '0;
            r_cfg.coef_err2       <= '0;
            r_cfg.coef_out1       <= '0;
            r_cfg.coef_out2       <= '0;
            r_cfg.setpoint        <= '0;
            r_cfg.friction_offset <= FRICTION_RST;
            r_cfg.drive_limit     <= LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/fpd_err_stage.sv]
// ----------------------------------------------------------------------------
// fpd_err_stage
// Input register: forms the saturated position error of each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_err_stage import fpd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    fpd_in_if.sink                       i_in,
    input  wire logic signed [ERR_W-1:0] i_setpoint,
    input  wire logic                    i_advance,
    output logic                         o_valid,
    output logic signed [ERR_W-1:0]      o_err
);

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W:0]   diff;
    logic signed [ERR_W-1:0] n_err;
    logic                    take;

    // Accept while empty or while the held beat moves on
    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;

    // Subtract with one guard bit, saturate on overflow
    always_comb begin
        diff = (ERR_W+1)'(i_setpoint) - (ERR_W+1)'(i_in.measured);
        if (diff[ERR_W] != diff[ERR_W-1]) begin
            n_err = diff[ERR_W] ? ERR_MIN : ERR_MAX;
        end else begin
            n_err = diff[ERR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Load payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_err <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;

endmodule

`default_nettype wire

[hw/rtl/fpd_law.sv]
// ----------------------------------------------------------------------------
// fpd_law
// Difference equation, clamp and friction offset; holds the error and drive
// history and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_law import fpd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  t_cfg                         i_cfg,
    input  wire logic                    i_valid,
    input  wire logic signed [ERR_W-1:0] i_err,
    output logic                         o_advance,
    fpd_out_if.source                    o_out
);

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_drive;
    logic                    r_clamped;
    logic signed [ERR_W-1:0] r_eh0;
    logic signed [ERR_W-1:0] r_eh1;
    logic signed [DRV_W-1:0] r_dh0;
    logic signed [DRV_W-1:0] r_dh1;

    logic signed [COEF_W-1:0]  c0, c1, c2, c3, c4;
    logic signed [EPROD_W-1:0] p0, p1, p2;
    logic signed [DPROD_W-1:0] p3, p4;
    logic signed [DTERM_W-1:0] t3, t4;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   lim_neg;
    logic signed [DRV_W-1:0]   n_u;
    logic                      n_clamped;
    logic signed [OUT_W-1:0]   fric;
    logic signed [OUT_W-1:0]   n_drive;
    logic                      step;

    assign o_advance = !r_out_valid || o_out.ready;
    assign step      = i_valid && o_advance;

    // Five products, drive terms floored back to Q.16
    always_comb begin
        c0 = i_cfg.coef_err0;
        c1 = i_cfg.coef_err1;
        c2 = i_cfg.coef_err2;
        c3 = i_cfg.coef_out1;
        c4 = i_cfg.coef_out2;
        p0 = EPROD_W'(c0) * EPROD_W'(i_err);
        p1 = EPROD_W'(c1) * EPROD_W'(r_eh0);
        p2 = EPROD_W'(c2) * EPROD_W'(r_eh1);
        p3 = DPROD_W'(c3) * DPROD_W'(r_dh0);
        p4 = DPROD_W'(c4) * DPROD_W'(r_dh1);
        t3 = p3[DPROD_W-1:FRAC_W];
        t4 = p4[DPROD_W-1:FRAC_W];
        sum = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(t3) + ACC_W'(t4);
    end

    // Clamp to plus or minus the limit
    always_comb begin
        lim_pos = ACC_W'({i_cfg.drive_limit, {FRAC_W{1'b0}}});
        lim_neg = -lim_pos;
        if (sum > lim_pos) begin
            n_u       = lim_pos[DRV_W-1:0];
            n_clamped = 1'b1;
        end else if (sum < lim_neg) begin
            n_u       = lim_neg[DRV_W-1:0];
            n_clamped = 1'b1;
        end else begin
            n_u       = sum[DRV_W-1:0];
            n_clamped = 1'b0;
        end
    end

    // Add friction offset by error sign, none at zero error
    always_comb begin
        fric = OUT_W'({i_cfg.friction_offset, {FRAC_W{1'b0}}});
        if (i_err[ERR_W-1]) begin
            n_drive = OUT_W'(n_u) - fric;
        end else if (i_err != '0) begin
            n_drive = OUT_W'(n_u) + fric;
        end else begin
            n_drive = OUT_W'(n_u);
        end
    end

    // Shift history on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eh0 <= '0;
            r_eh1 <= '0;
            r_dh0 <= '0;
            r_dh1 <= '0;
        end else if (step) begin
            r_eh0 <= i_err;
            r_eh1 <= r_eh0;
            r_dh0 <= n_u;
            r_dh1 <= r_dh0;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_drive;
    assign o_out.clamped = r_clamped;

endmodule

`default_nettype wire

[hw/rtl/filtered_pid_drive_unit.sv]
// ----------------------------------------------------------------------------
// filtered_pid_drive_unit
// PID position controller with filtered derivative as a second-order
// difference equation, drive clamp and coulomb friction offset.
//
//   channel  dir  payload                        beat taken when
//   i_in     in   measured[31:0] signed          valid && ready
//   o_out    out  drive[25:0] signed, clamped    valid && ready
//   i_cfg    in   index[2:0], data[31:0]         valid && ready (ready = 1)
//
// One beat per cycle sustained while the result side is ready. The error is
// formed in the input register; the five products, sum, clamp and offset
// sit combinationally ahead of the result register, as the previous drive
// feeds back into the next product.
// Synchronous active-low reset clears history, valids and the register file.
// A stalled result holds while the input register can still take one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_pid_drive_unit import fpd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpd_in_if.sink    i_in,
    fpd_out_if.source o_out,
    fpd_cfg_if.sink   i_cfg
);

    t_cfg                    cfg;
    logic                    err_valid;
    logic signed [ERR_W-1:0] err;
    logic                    advance;

    fpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fpd_err_stage u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_setpoint (cfg.setpoint),
        .i_advance  (advance),
        .o_valid    (err_valid),
        .o_err      (err)
    );

    fpd_law u_law (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (err_valid),
        .i_err     (err),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/fpd_checker.sv]
// ----------------------------------------------------------------------------
// fpd_checker
// Port-level checks of the drive unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fpd_checker import fpd_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [OUT_W-1:0] i_out_drive,
    input wire logic                    i_out_clamped
);

    logic           out_stall;
    logic [OUT_W:0] out_beat;
    logic           drive_in_range;

    assign out_stall      = i_out_valid && !i_out_ready;
    assign out_beat       = {i_out_drive, i_out_clamped};
    assign drive_in_range = (i_out_drive <= DRIVE_MAX) && (i_out_drive >= -DRIVE_MAX);

    // Stalled result holds
    `FPD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_beat))

    // Drive stays within limit plus offset range
    `FPD_ASSERT_IMP(a_drive_range, i_clk, i_rst_n, i_out_valid, drive_in_range)

    // Empty result register never blocks the input
    `FPD_ASSERT_IMP(a_no_block, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // Reset empties the result register
    `FPD_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind filtered_pid_drive_unit fpd_checker u_fpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_drive   (o_out.drive),
    .i_out_clamped (o_out.clamped)
);

`default_nettype wire

[tb/tb_filtered_pid_drive_unit.sv]
// ----------------------------------------------------------------------------
// tb_filtered_pid_drive_unit
// Self-checking bench for the filtered PID drive unit. A directed table covers
// the reset state, error saturation, drive extremes, zero error and a zero
// drive limit, and is followed by randomized phases, each with a fresh
// register setting. Result beats are checked in order against a row's typed
// value or a bit-exact bench model of the difference equation. Both channel
// ends idle at random; the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------

module tb_filtered_pid_drive_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fpd_pkg::*;

    localparam int SUM_W        = EPROD_W + 6;   // exact five-term sum
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_MARGIN = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic signed [OUT_W-1:0] drive;
        logic                    clamped;
    } t_drive_beat;

    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   val;     // register data or measured position
        bit                      typed;   // expected result given in the row
        logic signed [OUT_W-1:0] drive;
        logic                    clamped;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpd_in_if  in_ch ();
    fpd_out_if out_ch ();
    fpd_cfg_if cfg_ch ();

    filtered_pid_drive_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Controller image: registers and history
    t_cfg                    ctl_cfg;
    logic signed [ERR_W-1:0] err_hist [2];
    logic signed [DRV_W-1:0] drv_hist [2];

    t_drive_beat pending_drive_q [$];
    t_stim_row   dir_rows [$];

    // Typed expectation that travels with the current input beat
    bit                      typed_vld = 1'b0;
    logic signed [OUT_W-1:0] typed_drive = '0;
    logic                    typed_clamped = 1'b0;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int fail_cnt = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------

    function automatic void ctl_reset();
        ctl_cfg                 = '0;
        ctl_cfg.friction_offset = FRICTION_RST;
        ctl_cfg.drive_limit     = LIMIT_RST;
        err_hist[0] = '0;
        err_hist[1] = '0;
        drv_hist[0] = '0;
        drv_hist[1] = '0;
    endfunction

    function automatic void ctl_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_COEF_ERR0: ctl_cfg.coef_err0       = val;
            REG_COEF_ERR1: ctl_cfg.coef_err1       = val;
            REG_COEF_ERR2: ctl_cfg.coef_err2       = val;
            REG_COEF_OUT1: ctl_cfg.coef_out1       = val;
            REG_COEF_OUT2: ctl_cfg.coef_out2       = val;
            REG_SETPOINT:  ctl_cfg.setpoint        = val;
            REG_FRICTION:  ctl_cfg.friction_offset = val[LIM_W-1:0];
            REG_LIMIT:     ctl_cfg.drive_limit     = val[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    // One control step: saturate the error, sum the five terms exactly,
    // clamp, shift history, add friction by the error's sign.
    function automatic t_drive_beat ctl_step(input logic signed [ERR_W-1:0] meas);
        logic signed [ERR_W:0]   diff;
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        logic signed [SUM_W-1:0] held;
        logic signed [DRV_W-1:0] u;
        logic signed [OUT_W-1:0] base;
        logic signed [OUT_W-1:0] fric;
        t_drive_beat             res;

        diff = (ERR_W+1)'(ctl_cfg.setpoint) - (ERR_W+1)'(meas);
        if (diff > ERR_MAX) begin
            err = ERR_MAX;
        end else if (diff < ERR_MIN) begin
            err = ERR_MIN;
        end else begin
            err = diff[ERR_W-1:0];
        end

        sum = SUM_W'(ctl_cfg.coef_err0) * SUM_W'(err)
            + SUM_W'(ctl_cfg.coef_err1) * SUM_W'(err_hist[0])
            + SUM_W'(ctl_cfg.coef_err2) * SUM_W'(err_hist[1])
            + ((SUM_W'(ctl_cfg.coef_out1) * SUM_W'(drv_hist[0])) >>> FRAC_W)
            + ((SUM_W'(ctl_cfg.coef_out2) * SUM_W'(drv_hist[1])) >>> FRAC_W);

        lim = $signed({{(SUM_W - LIM_W - FRAC_W){1'b0}}, ctl_cfg.drive_limit,
                       {FRAC_W{1'b0}}});
        res.clamped = 1'b1;
        if (sum > lim) begin
            held = lim;
        end else if (sum < -lim) begin
            held = -lim;
        end else begin
            held        = sum;
            res.clamped = 1'b0;
        end
        u = held[DRV_W-1:0];

        err_hist[1] = err_hist[0];
        err_hist[0] = err;
        drv_hist[1] = drv_hist[0];
        drv_hist[0] = u;

        base = OUT_W'(u);
        fric = $signed({2'b00, ctl_cfg.friction_offset, {FRAC_W{1'b0}}});
        if (err > 0) begin
            res.drive = base + fric;
        end else if (err < 0) begin
            res.drive = base - fric;
        end else begin
            res.drive = base;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor: track register writes, predict on input beats, check
    // result beats in order
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : beat_monitor
        t_drive_beat pred;
        t_drive_beat want;

        if (i_rst_n === 1'b1) begin
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
                ctl_write(cfg_ch.index, cfg_ch.data);
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                pred = ctl_step(in_ch.measured);
                if (typed_vld) begin
                    pred.drive   = typed_drive;
                    pred.clamped = typed_clamped;
                end
                pending_drive_q.push_back(pred);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_drive_q.size() == 0) begin
                    $error("result beat with nothing pending: drive %0d clamped %0b",
                           out_ch.drive, out_ch.clamped);
                    fail_cnt++;
                end else begin
                    want = pending_drive_q.pop_front();
                    if (out_ch.drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, out_ch.drive);
                        fail_cnt++;
                    end
                    if (out_ch.clamped !== want.clamped) begin
                        $error("clamped: expected %0b, got %0b",
                               want.clamped, out_ch.clamped);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int stall;

        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        dir_rows.push_back('{ROW_REG, idx, val, 1'b0, '0, 1'b0});
    endfunction

    function automatic void item_row(input logic signed [ERR_W-1:0] meas, input bit typed,
                                     input logic signed [OUT_W-1:0] drive,
                                     input logic clamped);
        dir_rows.push_back('{ROW_ITEM, '0, meas, typed, drive, clamped});
    endfunction

    // Offer one measurement after a random gap and hold it until taken
    task automatic send_meas(input logic signed [ERR_W-1:0] meas, input bit typed,
                             input logic signed [OUT_W-1:0] drive, input logic clamped);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.measured <= meas;
        typed_vld      <= typed;
        typed_drive    <= drive;
        typed_clamped  <= clamped;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Leave valid high; the caller drops it after the last write of a batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // Stop offering and wait until every predicted beat has been checked
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coef(input bit fb, input bit edge_case);
        int unsigned r;
        int          span;

        r    = $urandom_range(0, 9);
        span = fb ? (1 << 17) : (1 << 14);
        if (edge_case || r == 0) begin
            case ($urandom_range(0, 2))
                0:       return ERR_MIN;
                1:       return ERR_MAX;
                default: return '0;
            endcase
        end
        if (r == 1) return $urandom;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setpoint();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    // Mostly near the setpoint, with zero error, extremes and noise mixed in
    function automatic logic signed [ERR_W-1:0] pick_meas();
        logic signed [ERR_W-1:0] sp;
        int unsigned             r;

        sp = ctl_cfg.setpoint;
        r  = $urandom_range(0, 9);
        case (r)
            0: return $urandom;
            1: return sp;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return ERR_MIN;
                    1:       return ERR_MAX;
                    2:       return sp + 1;
                    default: return sp - 1;
                endcase
            end
            default: return sp - (int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : main_seq
        bit                     cfg_open;
        logic [CFG_DATA_W-1:0]  word;
        t_stim_row              row;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.measured <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        ctl_reset();

        // Reset state: zero coefficients, friction 32, limit 255
        item_row(32'sd0, 1'b1, 26'sd0, 1'b0);
        item_row(32'sd5, 1'b1, -26'sd2097152, 1'b0);
        item_row(ERR_MIN, 1'b1, 26'sd2097152, 1'b0);      // error saturates high
        item_row(ERR_MAX, 1'b1, -26'sd2097152, 1'b0);
        // Full-scale gain: drive reaches both extremes, zero error adds nothing
        reg_row(REG_SETPOINT, ERR_MAX);
        reg_row(REG_FRICTION, 32'd255);
        reg_row(REG_COEF_ERR0, ERR_MAX);
        item_row(ERR_MIN, 1'b1, DRIVE_MAX, 1'b1);
        reg_row(REG_SETPOINT, ERR_MIN);
        item_row(ERR_MAX, 1'b1, -DRIVE_MAX, 1'b1);       // error saturates low
        item_row(ERR_MIN, 1'b1, 26'sd0, 1'b0);
        // Zero drive limit: only the friction offset is left
        reg_row(REG_SETPOINT, 32'd0);
        reg_row(REG_LIMIT, 32'd0);
        reg_row(REG_COEF_ERR0, 32'h0001_0000);
        item_row(-32'sd100, 1'b1, 26'sd16711680, 1'b1);
        item_row(32'sd100, 1'b1, -26'sd16711680, 1'b1);
        item_row(32'sd0, 1'b1, 26'sd0, 1'b0);
        // Extreme coefficients on every term
        reg_row(REG_LIMIT, 32'd255);
        reg_row(REG_FRICTION, 32'd0);
        reg_row(REG_COEF_ERR0, 32'h8000_0000);
        reg_row(REG_COEF_ERR1, 32'h7FFF_FFFF);
        reg_row(REG_COEF_ERR2, 32'h8000_0000);
        reg_row(REG_COEF_OUT1, 32'h7FFF_FFFF);
        reg_row(REG_COEF_OUT2, 32'h8000_0000);
        item_row(ERR_MIN, 1'b0, '0, 1'b0);
        item_row(ERR_MAX, 1'b0, '0, 1'b0);
        item_row(32'sd0, 1'b0, '0, 1'b0);
        item_row(32'sd1, 1'b0, '0, 1'b0);
        item_row(-32'sd1, 1'b0, '0, 1'b0);
        item_row(32'sh5555_5555, 1'b0, '0, 1'b0);
        item_row(32'shAAAA_AAAA, 1'b0, '0, 1'b0);
        // Fractional gains with feedback; limit byte under set upper bits
        reg_row(REG_LIMIT, 32'hFFFF_FF64);
        reg_row(REG_FRICTION, 32'd32);
        reg_row(REG_COEF_ERR0, 32'h0000_4000);
        reg_row(REG_COEF_ERR1, 32'hFFFF_A000);
        reg_row(REG_COEF_ERR2, 32'h0000_1000);
        reg_row(REG_COEF_OUT1, 32'h0001_8000);
        reg_row(REG_COEF_OUT2, 32'hFFFF_7FFF);
        item_row(32'sd37, 1'b0, '0, 1'b0);
        item_row(-32'sd3, 1'b0, '0, 1'b0);
        item_row(32'sd250, 1'b0, '0, 1'b0);
        item_row(-32'sd1000, 1'b0, '0, 1'b0);
        item_row(32'sd0, 1'b0, '0, 1'b0);
        item_row(32'sd7, 1'b0, '0, 1'b0);
        item_row(32'sd12345, 1'b0, '0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; drain before each batch of writes
        cfg_open = 1'b0;
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.kind == ROW_REG) begin
                if (!cfg_open) begin
                    wait_drained();
                    cfg_open = 1'b1;
                end
                cfg_write(row.idx, row.val);
            end else begin
                if (cfg_open) begin
                    cfg_ch.valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_meas(row.val, row.typed, row.drive, row.clamped);
            end
        end

        // Random phases, each with a new setting of every register
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            cfg_write(REG_COEF_ERR0, pick_coef(1'b0, ph == 1));
            cfg_write(REG_COEF_ERR1, pick_coef(1'b0, ph == 1));
            cfg_write(REG_COEF_ERR2, pick_coef(1'b0, ph == 1));
            cfg_write(REG_COEF_OUT1, pick_coef(1'b1, ph == 1));
            cfg_write(REG_COEF_OUT2, pick_coef(1'b1, ph == 1));
            cfg_write(REG_SETPOINT, pick_setpoint());
            word = $urandom;
            word[LIM_W-1:0] = (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 :
                              LIM_W'($urandom_range(0, 255));
            cfg_write(REG_FRICTION, word);
            word = $urandom;
            word[LIM_W-1:0] = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 :
                              LIM_W'($urandom_range(0, 255));
            cfg_write(REG_LIMIT, word);
            cfg_ch.valid <= 1'b0;

            // Hold off the result side while items keep coming
            if (ph == 3) hold_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (ph == 4) || ((ph == 3 || ph == 6) && k < 100);
                if (ph == 5 && k == 100) wait_drained();
                send_meas(pick_meas(), 1'b0, '0, 1'b0);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_MARGIN) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_filtered_pid_drive_unit: clean");
        end else begin
            $display("tb_filtered_pid_drive_unit: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycle_cnt;

        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_filtered_pid_drive_unit: errors");
        $finish;
    end

endmodule
